[sv/assert_macros.svh]
// Assertion shorthands shared by the morse key decoder RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge outside reset.
`define MKD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define MKD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MKD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mkd_pkg.sv]
// Shared types, register codes and the Morse code table for the key decoder.
// No dependencies; used by mkd_code_rom and morse_key_decoder_unit.
package mkd_pkg;

	localparam int MAX_SYMBOLS_DEF = 6;
	localparam int TIMER_BITS_DEF  = 16;
	localparam int CFG_W           = 16;
	localparam int TABLE_N         = 36;
	localparam int CODE_W          = 5;

	// event kinds
	localparam logic [1:0] FN_TICK = 2'd0;
	localparam logic [1:0] FN_DOWN = 2'd1;
	localparam logic [1:0] FN_UP   = 2'd2;

	// register indexes
	localparam logic [1:0] REG_TAP_MODE  = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_LETTER    = 2'd2;
	localparam logic [1:0] REG_WORD      = 2'd3;

	localparam logic             TAP_MODE_RST  = 1'b1;
	localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd300;
	localparam logic [CFG_W-1:0] LETTER_RST    = 16'd700;
	localparam logic [CFG_W-1:0] WORD_RST      = 16'd1400;

	localparam logic [6:0] ASCII_SPACE = 7'h20;
	localparam logic [6:0] CASE_BIT    = 7'h20;

	typedef struct packed {
		logic [1:0] func;
		logic       key_is_dash;
		logic       caps_lock_on;
		logic       shift_held;
	} mkd_in_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last_of_run;
	} mkd_out_t;

	// symbol i of a code sits at pat bit i, 1 = dash
	typedef struct packed {
		logic [2:0]        len;
		logic [CODE_W-1:0] pat;
		logic [6:0]        ch;
	} mkd_code_t;

	localparam mkd_code_t CODE_TABLE [TABLE_N] = '{
		'{3'd2, 5'b00010, 7'h41}, '{3'd4, 5'b00001, 7'h42}, '{3'd4, 5'b00101, 7'h43},
		'{3'd3, 5'b00001, 7'h44}, '{3'd1, 5'b00000, 7'h45}, '{3'd4, 5'b00100, 7'h46},
		'{3'd3, 5'b00011, 7'h47}, '{3'd4, 5'b00000, 7'h48}, '{3'd2, 5'b00000, 7'h49},
		'{3'd4, 5'b01110, 7'h4A}, '{3'd3, 5'b00101, 7'h4B}, '{3'd4, 5'b00010, 7'h4C},
		'{3'd2, 5'b00011, 7'h4D}, '{3'd2, 5'b00001, 7'h4E}, '{3'd3, 5'b00111, 7'h4F},
		'{3'd4, 5'b00110, 7'h50}, '{3'd4, 5'b01011, 7'h51}, '{3'd3, 5'b00010, 7'h52},
		'{3'd3, 5'b00000, 7'h53}, '{3'd1, 5'b00001, 7'h54}, '{3'd3, 5'b00100, 7'h55},
		'{3'd4, 5'b01000, 7'h56}, '{3'd3, 5'b00110, 7'h57}, '{3'd4, 5'b01001, 7'h58},
		'{3'd4, 5'b01101, 7'h59}, '{3'd4, 5'b00011, 7'h5A},
		'{3'd5, 5'b11111, 7'h30}, '{3'd5, 5'b11110, 7'h31}, '{3'd5, 5'b11100, 7'h32},
		'{3'd5, 5'b11000, 7'h33}, '{3'd5, 5'b10000, 7'h34}, '{3'd5, 5'b00000, 7'h35},
		'{3'd5, 5'b00001, 7'h36}, '{3'd5, 5'b00011, 7'h37}, '{3'd5, 5'b00111, 7'h38},
		'{3'd5, 5'b01111, 7'h39}
	};

endpackage

[sv/mkd_code_rom.sv]
// Code table lookup: matches the stored dot/dash pattern against A-Z and 0-9.
// Depends on mkd_pkg for the constant table.
module mkd_code_rom #(
	parameter int MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF,
	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1)
) (
	input  logic [MAX_SYMBOLS-1:0] bits,
	input  logic [CNT_W-1:0]       count,
	input  logic                   overflow,
	output logic                   hit,
	output logic [6:0]             ch
);

	logic [MAX_SYMBOLS-1:0] pat_ext [mkd_pkg::TABLE_N];
	logic [mkd_pkg::TABLE_N-1:0] match;

	// symbols past the count are always zero, so a full-width compare works
	always_comb begin
		for (int e = 0; e < mkd_pkg::TABLE_N; e++) begin
			pat_ext[e] = MAX_SYMBOLS'(mkd_pkg::CODE_TABLE[e].pat);
			match[e] = !overflow && (count == CNT_W'(mkd_pkg::CODE_TABLE[e].len)) &&
				(bits == pat_ext[e]);
		end
	end

	always_comb begin
		ch = '0;
		for (int e = 0; e < mkd_pkg::TABLE_N; e++) begin
			if (match[e]) ch = ch | mkd_pkg::CODE_TABLE[e].ch;
		end
	end

	assign hit = |match;

endmodule

[sv/morse_key_decoder_unit.sv]
// Morse key decoder top level: event input stage, decode state, result queue.
// Depends on mkd_pkg, mkd_code_rom and assert_macros.svh.
//
// Usage:
//   ev channel  - one beat per key event (tick, key down, key up) in ev_data.
//   ch channel  - decoded characters in ch_data; last_of_run marks the final
//                 character caused by one event (a tick may give a letter
//                 and a space).
//   cfg port    - cfg_we/cfg_index/cfg_data write tap mode, dash threshold,
//                 letter gap and word gap; write only while the block is idle.
// Path: an event beat is taken into the input register, then decoded into the
// result queue, whose head drives ch_valid and ch_data.
// Throughput: one event per cycle. The input register decodes when the
// four-entry result queue has room for two characters; otherwise it holds
// and raises ev_stall, so a stalled ch side backs up into the ev side
// without losing or reordering characters.
// Reset: queue and input register empty, all timers and symbols cleared,
// registers back to tap mode with 300/700/1400 ms thresholds.
`include "assert_macros.svh"

module morse_key_decoder_unit #(
	parameter int MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF,
	parameter int TIMER_BITS  = mkd_pkg::TIMER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ev_valid,
	output logic                    ev_stall,
	input  mkd_pkg::mkd_in_t        ev_data,
	output logic                    ch_valid,
	input  logic                    ch_stall,
	output mkd_pkg::mkd_out_t       ch_data,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [mkd_pkg::CFG_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int CMP_W = (TIMER_BITS > mkd_pkg::CFG_W) ? TIMER_BITS : mkd_pkg::CFG_W;
	localparam int Q_DEPTH = 4;
	localparam int QP_W = $clog2(Q_DEPTH);
	localparam int QC_W = $clog2(Q_DEPTH + 1);

	// configuration
	logic                      tap_mode_q;
	logic [mkd_pkg::CFG_W-1:0] thr_q, lgap_q, wgap_q;

	// input stage
	logic             valid_s1;
	mkd_pkg::mkd_in_t ev_s1;
	logic             room, adv;

	// decode state
	logic [MAX_SYMBOLS-1:0] sym_bits_q, sym_bits_d;
	logic [CNT_W-1:0]       sym_cnt_q, sym_cnt_d;
	logic                   ovf_q, ovf_d;
	logic [TIMER_BITS-1:0]  idle_q, idle_d, idle_inc;
	logic                   act_q, act_d;
	logic                   pend_q, pend_d;
	logic [TIMER_BITS-1:0]  hold_q [2];
	logic [TIMER_BITS-1:0]  hold_d [2];
	logic [1:0]             pressed_q, pressed_d;

	// lookup and results
	logic       rom_hit;
	logic [6:0] rom_ch;
	logic       commit, emit_letter, emit_space, pend_eff, sym;
	logic [6:0] letter;
	logic [1:0] n_res;
	mkd_pkg::mkd_out_t res0, res1;

	// result queue
	mkd_pkg::mkd_out_t fifo_q [Q_DEPTH];
	logic [QP_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QC_W-1:0]   fifo_cnt_q;
	logic              pop;

	mkd_code_rom #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_rom (
		.bits     (sym_bits_q),
		.count    (sym_cnt_q),
		.overflow (ovf_q),
		.hit      (rom_hit),
		.ch       (rom_ch)
	);

	assign room     = fifo_cnt_q <= QC_W'(Q_DEPTH - 2);
	assign adv      = valid_s1 && room;
	assign ev_stall = valid_s1 && !room;
	assign ch_valid = fifo_cnt_q != '0;
	assign ch_data  = fifo_q[rd_ptr_q];
	assign pop      = ch_valid && !ch_stall;

	assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;

	always_comb begin
		sym_bits_d  = sym_bits_q;
		sym_cnt_d   = sym_cnt_q;
		ovf_d       = ovf_q;
		idle_d      = idle_q;
		act_d       = act_q;
		pend_d      = pend_q;
		hold_d      = hold_q;
		pressed_d   = pressed_q;
		commit      = 1'b0;
		emit_letter = 1'b0;
		emit_space  = 1'b0;
		pend_eff    = pend_q;
		sym         = 1'b0;
		letter      = rom_ch;
		unique case (ev_s1.func)
			mkd_pkg::FN_TICK: begin
				for (int k = 0; k < 2; k++) begin
					if (pressed_q[k] && hold_q[k] != '1) hold_d[k] = hold_q[k] + 1'b1;
				end
				idle_d = idle_inc;
				commit = act_q && (CMP_W'(idle_inc) >= CMP_W'(lgap_q));
				emit_letter = commit && rom_hit;
				if (rom_ch[6] && !(ev_s1.caps_lock_on ^ ev_s1.shift_held))
					letter = rom_ch | mkd_pkg::CASE_BIT;
				pend_eff = pend_q || commit;
				emit_space = pend_eff && (CMP_W'(idle_inc) >= CMP_W'(wgap_q));
				pend_d = pend_eff && !emit_space;
				if (commit) begin
					sym_bits_d = '0;
					sym_cnt_d  = '0;
					ovf_d      = 1'b0;
					act_d      = 1'b0;
				end
			end
			mkd_pkg::FN_DOWN: begin
				pressed_d[ev_s1.key_is_dash] = 1'b1;
				hold_d[ev_s1.key_is_dash]    = '0;
			end
			mkd_pkg::FN_UP: begin
				if (tap_mode_q)
					sym = ev_s1.key_is_dash;
				else if (pressed_q[ev_s1.key_is_dash])
					sym = CMP_W'(hold_q[ev_s1.key_is_dash]) >= CMP_W'(thr_q);
				pressed_d[ev_s1.key_is_dash] = 1'b0;
				hold_d[ev_s1.key_is_dash]    = '0;
				if (sym_cnt_q < CNT_W'(MAX_SYMBOLS)) begin
					for (int i = 0; i < MAX_SYMBOLS; i++) begin
						if (sym_cnt_q == CNT_W'(i)) sym_bits_d[i] = sym;
					end
					sym_cnt_d = sym_cnt_q + 1'b1;
				end else begin
					ovf_d = 1'b1;
				end
				idle_d = '0;
				act_d  = 1'b1;
				pend_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// pack up to two results; the letter always goes first
	always_comb begin
		res0 = '{char_code: letter, last_of_run: !emit_space};
		res1 = '{char_code: mkd_pkg::ASCII_SPACE, last_of_run: 1'b1};
		n_res = {1'b0, emit_letter} + {1'b0, emit_space};
		if (!emit_letter) res0 = res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_mode_q <= mkd_pkg::TAP_MODE_RST;
			thr_q      <= mkd_pkg::THRESHOLD_RST;
			lgap_q     <= mkd_pkg::LETTER_RST;
			wgap_q     <= mkd_pkg::WORD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mkd_pkg::REG_TAP_MODE:  tap_mode_q <= cfg_data[0];
				mkd_pkg::REG_THRESHOLD: thr_q      <= cfg_data;
				mkd_pkg::REG_LETTER:    lgap_q     <= cfg_data;
				mkd_pkg::REG_WORD:      wgap_q     <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!ev_stall) begin
			valid_s1 <= ev_valid;
		end
	end

	// hold the beat while stalled
	always_ff @(posedge clk) begin
		if (ev_valid && !ev_stall) ev_s1 <= ev_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_bits_q <= '0;
			sym_cnt_q  <= '0;
			ovf_q      <= 1'b0;
			idle_q     <= '0;
			act_q      <= 1'b0;
			pend_q     <= 1'b0;
			hold_q     <= '{default: '0};
			pressed_q  <= '0;
		end else if (adv) begin
			sym_bits_q <= sym_bits_d;
			sym_cnt_q  <= sym_cnt_d;
			ovf_q      <= ovf_d;
			idle_q     <= idle_d;
			act_q      <= act_d;
			pend_q     <= pend_d;
			hold_q     <= hold_d;
			pressed_q  <= pressed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (adv) wr_ptr_q <= wr_ptr_q + QP_W'(n_res);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			fifo_cnt_q <= fifo_cnt_q + (adv ? QC_W'(n_res) : '0) - QC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_res != 2'd0) fifo_q[wr_ptr_q] <= res0;
		if (adv && n_res == 2'd2) fifo_q[wr_ptr_q + 1'b1] <= res1;
	end

	`MKD_ASSERT_ALWAYS(a_fifo_bound, fifo_cnt_q <= QC_W'(Q_DEPTH), "result queue overrun")
	`MKD_ASSERT_ALWAYS(a_sym_bound, sym_cnt_q <= CNT_W'(MAX_SYMBOLS), "symbol count too large")
	`MKD_ASSERT_IMP(a_idle_empty, !act_q, sym_cnt_q == '0 && !ovf_q, "symbols without activity")
	`MKD_ASSERT_NEXT(a_commit_clr, adv && commit, sym_cnt_q == '0 && pend_q == !$past(emit_space),
		"commit did not clear the code")

endmodule

[dv/morse_key_decoder_unit_test.sv]
`timescale 1ns / 100ps
// Testbench for morse_key_decoder_unit: directed and random key events, with
// an event-level decoder model, random idling on both sides and back-pressure.
// Depends on mkd_pkg and the morse_key_decoder_unit RTL.
module morse_key_decoder_unit_test;

	// event kind the block must ignore
	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int RX_HOLD_CYCLES = 400;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      ev_valid;
	logic                      ev_stall;
	mkd_pkg::mkd_in_t          ev_data;
	logic                      ch_valid;
	logic                      ch_stall;
	mkd_pkg::mkd_out_t         ch_data;
	logic                      cfg_we;
	logic [1:0]                cfg_index;
	logic [mkd_pkg::CFG_W-1:0] cfg_data;

	morse_key_decoder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev_stall  (ev_stall),
		.ev_data   (ev_data),
		.ch_valid  (ch_valid),
		.ch_stall  (ch_stall),
		.ch_data   (ch_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decoder model state
	logic        tap_mode_q;
	logic [15:0] dash_thr_q;
	logic [15:0] letter_gap_q;
	logic [15:0] word_gap_q;
	logic [5:0]  sym_bits;
	int          sym_count;
	bit          code_ovf;
	logic [15:0] idle_ms;
	bit          letter_open;
	bit          space_due;
	logic [15:0] hold_ms [2];
	bit          key_down [2];

	mkd_pkg::mkd_out_t pending_chars [$];
	int       mismatches = 0;
	int       items_sent = 0;
	bit       tx_random = 1'b1;
	bit       rx_random = 1'b1;
	int       hold_requests = 0;

	function automatic bit rbit();
		return bit'($urandom_range(0, 1));
	endfunction

	function automatic int limit_to(int v, int m);
		return (v < 0) ? 0 : ((v > m) ? m : v);
	endfunction

	function automatic void reset_decoder_model();
		tap_mode_q   = 1'b1;
		dash_thr_q   = 16'd300;
		letter_gap_q = 16'd700;
		word_gap_q   = 16'd1400;
		sym_bits     = '0;
		sym_count    = 0;
		code_ovf     = 1'b0;
		idle_ms      = '0;
		letter_open  = 1'b0;
		space_due    = 1'b0;
		hold_ms[0]   = '0;
		hold_ms[1]   = '0;
		key_down[0]  = 1'b0;
		key_down[1]  = 1'b0;
	endfunction

	function automatic logic [15:0] sat_inc16(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Uppercase ASCII for the stored symbols, zero when the code is unknown.
	function automatic logic [6:0] decode_symbols();
		string code;
		logic [7:0] ch;
		int i;
		code = "";
		if (code_ovf || sym_count == 0)
			return 7'd0;
		for (i = 0; i < sym_count; i++) begin
			if (sym_bits[i])
				code = {code, "-"};
			else
				code = {code, "."};
		end
		case (code)
		".-":    ch = "A";
		"-...":  ch = "B";
		"-.-.":  ch = "C";
		"-..":   ch = "D";
		".":     ch = "E";
		"..-.":  ch = "F";
		"--.":   ch = "G";
		"....":  ch = "H";
		"..":    ch = "I";
		".---":  ch = "J";
		"-.-":   ch = "K";
		".-..":  ch = "L";
		"--":    ch = "M";
		"-.":    ch = "N";
		"---":   ch = "O";
		".--.":  ch = "P";
		"--.-":  ch = "Q";
		".-.":   ch = "R";
		"...":   ch = "S";
		"-":     ch = "T";
		"..-":   ch = "U";
		"...-":  ch = "V";
		".--":   ch = "W";
		"-..-":  ch = "X";
		"-.--":  ch = "Y";
		"--..":  ch = "Z";
		"-----": ch = "0";
		".----": ch = "1";
		"..---": ch = "2";
		"...--": ch = "3";
		"....-": ch = "4";
		".....": ch = "5";
		"-....": ch = "6";
		"--...": ch = "7";
		"---..": ch = "8";
		"----.": ch = "9";
		default: ch = 8'h00;
		endcase
		return ch[6:0];
	endfunction

	// Advance the model by one event beat and queue the characters it yields.
	function automatic void decode_event(mkd_pkg::mkd_in_t ev);
		mkd_pkg::mkd_out_t outs [$];
		mkd_pkg::mkd_out_t o;
		logic sym;
		logic [6:0] ch;
		int k;
		int i;
		k = int'(ev.key_is_dash);
		case (ev.func)
		mkd_pkg::FN_DOWN: begin
			key_down[k] = 1'b1;
			hold_ms[k]  = '0;
		end
		mkd_pkg::FN_UP: begin
			if (tap_mode_q)
				sym = ev.key_is_dash;
			else if (key_down[k])
				sym = (hold_ms[k] >= dash_thr_q);
			else
				sym = 1'b0;
			key_down[k] = 1'b0;
			hold_ms[k]  = '0;
			if (sym_count < mkd_pkg::MAX_SYMBOLS_DEF) begin
				sym_bits[sym_count] = sym;
				sym_count++;
			end else begin
				code_ovf = 1'b1;
			end
			idle_ms     = '0;
			letter_open = 1'b1;
			space_due   = 1'b0;
		end
		mkd_pkg::FN_TICK: begin
			for (i = 0; i < 2; i++)
				if (key_down[i])
					hold_ms[i] = sat_inc16(hold_ms[i]);
			idle_ms = sat_inc16(idle_ms);
			if (letter_open && idle_ms >= letter_gap_q) begin
				ch = decode_symbols();
				if (ch != 7'd0) begin
					if (ch >= "A" && ch <= "Z" && !(ev.caps_lock_on ^ ev.shift_held))
						ch = ch | mkd_pkg::CASE_BIT;
					o.char_code   = ch;
					o.last_of_run = 1'b0;
					outs = {outs, o};
				end
				sym_bits    = '0;
				sym_count   = 0;
				code_ovf    = 1'b0;
				letter_open = 1'b0;
				space_due   = 1'b1;
			end
			if (space_due && idle_ms >= word_gap_q) begin
				o.char_code   = mkd_pkg::ASCII_SPACE;
				o.last_of_run = 1'b0;
				outs = {outs, o};
				space_due = 1'b0;
			end
			if (outs.size() > 0)
				outs[outs.size() - 1].last_of_run = 1'b1;
		end
		default: ;
		endcase
		pending_chars = {pending_chars, outs};
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	// check each character beat against the oldest expected one
	always @(posedge clk) begin : check_chars
		mkd_pkg::mkd_out_t want;
		if (arst_n && ch_valid && !ch_stall) begin
			if (pending_chars.size() == 0) begin
				note_mismatch($sformatf("unexpected char 0x%02h last %0b",
					ch_data.char_code, ch_data.last_of_run));
			end else begin
				want = pending_chars.pop_front();
				if (ch_data.char_code !== want.char_code)
					note_mismatch($sformatf("char_code: want 0x%02h, got 0x%02h",
						want.char_code, ch_data.char_code));
				else if (ch_data.last_of_run !== want.last_of_run)
					note_mismatch($sformatf("last_of_run after 0x%02h: want %0b, got %0b",
						want.char_code, want.last_of_run, ch_data.last_of_run));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin : drive_ch_stall
		int stall_left;
		int hold_left;
		int holds_served;
		int r;
		stall_left   = 0;
		hold_left    = 0;
		holds_served = 0;
		ch_stall     = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left    = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ch_stall <= 1'b1;
			end else if (!rx_random) begin
				ch_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				ch_stall <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					ch_stall <= 1'b0;
				end else begin
					stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
					ch_stall <= 1'b1;
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (!tx_random)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one event beat and hold it until taken; valid stays high on return.
	task automatic send_event(logic [1:0] func, logic key, logic caps, logic shift);
		mkd_pkg::mkd_in_t ev;
		int gap;
		ev.func         = func;
		ev.key_is_dash  = key;
		ev.caps_lock_on = caps;
		ev.shift_held   = shift;
		gap = pick_gap();
		if (gap > 0) begin
			ev_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ev_valid <= 1'b1;
		ev_data  <= ev;
		do
			@(posedge clk);
		while (ev_stall);
		decode_event(ev);
		if (func != FN_UNUSED)
			items_sent++;
	endtask

	task automatic send_ticks(int n, logic caps, logic shift);
		repeat (n) send_event(mkd_pkg::FN_TICK, rbit(), caps, shift);
	endtask

	task automatic tap_key(logic dash);
		send_event(mkd_pkg::FN_DOWN, dash, rbit(), rbit());
		send_event(mkd_pkg::FN_UP, dash, rbit(), rbit());
	endtask

	// Drop valid and drain every expected character, then let the pipe settle.
	task automatic wait_idle();
		ev_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [mkd_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
		mkd_pkg::REG_TAP_MODE:  tap_mode_q   = val[0];
		mkd_pkg::REG_THRESHOLD: dash_thr_q   = val;
		mkd_pkg::REG_LETTER:    letter_gap_q = val;
		mkd_pkg::REG_WORD:      word_gap_q   = val;
		default: ;
		endcase
	endtask

	task automatic set_config(logic tap, logic [15:0] thr, logic [15:0] lg, logic [15:0] wg);
		wait_idle();
		write_reg(mkd_pkg::REG_TAP_MODE, {15'd0, tap});
		write_reg(mkd_pkg::REG_THRESHOLD, thr);
		write_reg(mkd_pkg::REG_LETTER, lg);
		write_reg(mkd_pkg::REG_WORD, wg);
		cfg_we <= 1'b0;
	endtask

	// reset values: tap mode and a 700 ms letter gap
	task automatic test_reset_defaults();
		tap_key(1'b1);
		send_ticks(700, 1'b0, 1'b1);
	endtask

	task automatic test_tap_letters();
		set_config(1'b1, 16'd3, 16'd2, 16'd4);
		tap_key(1'b0);
		tap_key(1'b1);
		send_ticks(4, 1'b0, 1'b0);
		// digit ignores the case rule
		repeat (5) tap_key(1'b1);
		send_ticks(4, 1'b1, 1'b1);
		tap_key(1'b1);
		tap_key(1'b1);
		tap_key(1'b0);
		tap_key(1'b1);
		send_ticks(4, 1'b1, 1'b0);
		// unknown code: no letter, space still follows
		repeat (6) tap_key(1'b0);
		send_ticks(4, 1'b0, 1'b0);
		// too many symbols
		repeat (7) tap_key(1'b1);
		send_ticks(4, 1'b1, 1'b0);
		send_event(FN_UNUSED, 1'b1, 1'b1, 1'b1);
		// a release cancels the pending space
		tap_key(1'b0);
		send_ticks(3, 1'b0, 1'b1);
		tap_key(1'b1);
		send_ticks(4, 1'b0, 1'b0);
	endtask

	task automatic test_duration_mode();
		set_config(1'b0, 16'd3, 16'd2, 16'd2);
		send_event(mkd_pkg::FN_UP, 1'b0, 1'b0, 1'b0);
		send_event(mkd_pkg::FN_DOWN, 1'b1, 1'b0, 1'b0);
		send_ticks(3, 1'b0, 1'b0);
		send_event(mkd_pkg::FN_UP, 1'b1, 1'b0, 1'b0);
		// second press restarts the hold, so this one is a dot
		send_event(mkd_pkg::FN_DOWN, 1'b1, 1'b1, 1'b1);
		send_ticks(2, 1'b1, 1'b1);
		send_event(mkd_pkg::FN_DOWN, 1'b1, 1'b1, 1'b1);
		send_ticks(1, 1'b1, 1'b1);
		send_event(mkd_pkg::FN_UP, 1'b1, 1'b1, 1'b1);
		send_ticks(2, 1'b0, 1'b0);
	endtask

	task automatic test_zero_limits();
		set_config(1'b0, 16'd0, 16'd0, 16'd0);
		tap_key(1'b0);
		send_ticks(2, 1'b1, 1'b0);
	endtask

	task automatic test_backpressure();
		set_config(1'b1, 16'd3, 16'd1, 16'd1);
		tx_random = 1'b0;
		hold_requests++;
		repeat (30) begin
			tap_key(rbit());
			send_ticks(1, rbit(), rbit());
		end
		tx_random = 1'b1;
	endtask

	task automatic send_random_letter();
		int nsym;
		int i;
		int lo;
		int hi;
		logic key;
		nsym = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
		for (i = 0; i < nsym; i++) begin
			key = rbit();
			if ($urandom_range(0, 19) != 0)
				send_event(mkd_pkg::FN_DOWN, key, rbit(), rbit());
			if ($urandom_range(0, 19) == 0) begin
				send_ticks($urandom_range(0, 3), rbit(), rbit());
				send_event(mkd_pkg::FN_DOWN, key, rbit(), rbit());
			end
			send_ticks($urandom_range(0, limit_to(2 * int'(dash_thr_q), 12)), rbit(), rbit());
			send_event(mkd_pkg::FN_UP, key, rbit(), rbit());
			if (i < nsym - 1)
				send_ticks($urandom_range(0, limit_to(int'(letter_gap_q) - 1, 8)),
					rbit(), rbit());
		end
		if ($urandom_range(0, 7) == 0)
			send_event(2'($urandom_range(0, 3)), rbit(), rbit(), rbit());
		lo = limit_to(int'(letter_gap_q), 20);
		hi = limit_to(int'(word_gap_q) + 2, 30);
		if (hi < lo)
			hi = lo;
		send_ticks($urandom_range(lo, hi), rbit(), rbit());
	endtask

	task automatic test_random_traffic();
		int start;
		int r;
		logic [15:0] thr;
		logic [15:0] lg;
		logic [15:0] wg;
		start = items_sent;
		while (items_sent - start < 580) begin
			r = $urandom_range(0, 99);
			thr = (r < 8) ? 16'hFFFF : ((r < 14) ? 16'd1 : 16'($urandom_range(1, 6)));
			r = $urandom_range(0, 99);
			lg = (r < 5) ? 16'hFFFF : ((r < 15) ? 16'd1 : 16'($urandom_range(2, 8)));
			r = $urandom_range(0, 99);
			wg = (r < 5) ? 16'hFFFF : ((r < 15) ? 16'd1 : 16'($urandom_range(1, 16)));
			set_config(rbit(), thr, lg, wg);
			tx_random = ($urandom_range(0, 3) != 0);
			rx_random = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(6, 14)) send_random_letter();
		end
		tx_random = 1'b1;
		rx_random = 1'b1;
	endtask

	initial begin
		arst_n    = 1'b0;
		ev_valid  = 1'b0;
		ev_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = mkd_pkg::REG_TAP_MODE;
		cfg_data  = '0;
		reset_decoder_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_tap_letters();
		test_duration_mode();
		test_zero_limits();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_chars.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/mkd_pkg.sv
sv/mkd_code_rom.sv
sv/morse_key_decoder_unit.sv
dv/morse_key_decoder_unit_test.sv
